@@ sv/mpdv_pkg.sv @@
// ----------------------------------------------------------------------------
// mpdv_pkg
// Shared types, constants and the arithmetic micro-program of the matched
// point difference vector unit.
// ----------------------------------------------------------------------------
package mpdv_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// request modes
	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_EVAL  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// configuration register index
	localparam logic REG_SCALE = 1'b0;
	localparam logic [31:0] SCALE_RESET = 32'h0001_0000;

	// accumulator width: holds the largest exact sum of products, signed
	localparam int ACC_W = 97;

	// micro-program length
	localparam int NSTEPS = 24;
	localparam int STEP_W = $clog2(NSTEPS);

	// micro-op kinds
	localparam logic [3:0] K_NOP      = 4'd0;
	localparam logic [3:0] K_MAG      = 4'd1;
	localparam logic [3:0] K_S2       = 4'd2;
	localparam logic [3:0] K_OM2      = 4'd3;
	localparam logic [3:0] K_INIT_ROW = 4'd4;
	localparam logic [3:0] K_INIT_COL = 4'd5;
	localparam logic [3:0] K_MAC      = 4'd6;
	localparam logic [3:0] K_FIN_ROW  = 4'd7;
	localparam logic [3:0] K_FIN_COL  = 4'd8;
	localparam logic [3:0] K_FIN_VR   = 4'd9;
	localparam logic [3:0] K_FIN_VC   = 4'd10;
	localparam logic [3:0] K_FIN_COV  = 4'd11;

	// multiplier operand a selects
	localparam logic [2:0] A_S     = 3'd0;
	localparam logic [2:0] A_OMS   = 3'd1;
	localparam logic [2:0] A_DR    = 3'd2;
	localparam logic [2:0] A_DC    = 3'd3;
	localparam logic [2:0] A_S2LO  = 3'd4;
	localparam logic [2:0] A_S2HI  = 3'd5;
	localparam logic [2:0] A_OM2LO = 3'd6;
	localparam logic [2:0] A_OM2HI = 3'd7;

	// multiplier operand b selects
	localparam logic [2:0] B_S   = 3'd0;
	localparam logic [2:0] B_OMS = 3'd1;
	localparam logic [2:0] B_MVR = 3'd2;
	localparam logic [2:0] B_VR  = 3'd3;
	localparam logic [2:0] B_MVC = 3'd4;
	localparam logic [2:0] B_VC  = 3'd5;
	localparam logic [2:0] B_MCV = 3'd6;
	localparam logic [2:0] B_CV  = 3'd7;

	typedef struct packed {
		logic [3:0] kind;
		logic [2:0] a_sel;
		logic [2:0] b_sel;
		logic       sh32;
	} uop_t;

	// one stored or presented point
	typedef struct packed {
		logic [26:0] num;
		logic [31:0] row;
		logic [31:0] col;
		logic [30:0] var_row;
		logic [30:0] var_col;
		logic [31:0] cov;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic              load_ref;
		logic              capture_hit;
		logic [STEP_W-1:0] step;
		logic              phase;
		logic              out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic match;
	} status_t;

	// controller to table
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [ADDR_W-1:0] rd_addr;
	} tbl_cmd_t;

	// arithmetic micro-program
	function automatic uop_t uop_at(input logic [STEP_W-1:0] step);
		uop_t u;
		u = '{kind: K_NOP, a_sel: A_S, b_sel: B_S, sh32: 1'b0};
		unique case (step)
			5'd0:  u = '{K_MAG,      A_S,     B_S,   1'b0};
			5'd1:  u = '{K_S2,       A_S,     B_S,   1'b0};
			5'd2:  u = '{K_OM2,      A_OMS,   B_OMS, 1'b0};
			5'd3:  u = '{K_INIT_ROW, A_S,     B_S,   1'b0};
			5'd4:  u = '{K_MAC,      A_DR,    B_S,   1'b0};
			5'd5:  u = '{K_FIN_ROW,  A_S,     B_S,   1'b0};
			5'd6:  u = '{K_INIT_COL, A_S,     B_S,   1'b0};
			5'd7:  u = '{K_MAC,      A_DC,    B_S,   1'b0};
			5'd8:  u = '{K_FIN_COL,  A_S,     B_S,   1'b0};
			5'd9:  u = '{K_MAC,      A_S2LO,  B_MVR, 1'b0};
			5'd10: u = '{K_MAC,      A_S2HI,  B_MVR, 1'b1};
			5'd11: u = '{K_MAC,      A_OM2LO, B_VR,  1'b0};
			5'd12: u = '{K_MAC,      A_OM2HI, B_VR,  1'b1};
			5'd13: u = '{K_FIN_VR,   A_S,     B_S,   1'b0};
			5'd14: u = '{K_MAC,      A_S2LO,  B_MVC, 1'b0};
			5'd15: u = '{K_MAC,      A_S2HI,  B_MVC, 1'b1};
			5'd16: u = '{K_MAC,      A_OM2LO, B_VC,  1'b0};
			5'd17: u = '{K_MAC,      A_OM2HI, B_VC,  1'b1};
			5'd18: u = '{K_FIN_VC,   A_S,     B_S,   1'b0};
			5'd19: u = '{K_MAC,      A_S2LO,  B_MCV, 1'b0};
			5'd20: u = '{K_MAC,      A_S2HI,  B_MCV, 1'b1};
			5'd21: u = '{K_MAC,      A_OM2LO, B_CV,  1'b0};
			5'd22: u = '{K_MAC,      A_OM2HI, B_CV,  1'b1};
			5'd23: u = '{K_FIN_COV,  A_S,     B_S,   1'b0};
			default: u = '{K_NOP,    A_S,     B_S,   1'b0};
		endcase
		return u;
	endfunction

endpackage

@@ sv/matched_point_difference_vector.sv @@
// ----------------------------------------------------------------------------
// matched_point_difference_vector
// Table of measured points matched by number against reference points,
// producing one exaggerated difference vector per match.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream takes requests; s_tuser is the mode (load, evaluate, clear).
//   A load stores a measured point (dropped when the table is full), a clear
//   empties the table; neither gives a result.
//   An evaluate searches stored points in load order, one entry per cycle
//   (one table read port, compare in the cycle after the read), and on the
//   first number match gives one result on m_*; no match gives none.
//   On a match the shared 32x32 multiply-accumulate unit runs the 24
//   micro-ops, each a multiply then an accumulate, then comes a handoff
//   state, and m_tvalid rises the cycle after the handoff.
//   Requests are taken only between evaluations.
//   A finished result waits in the output register; while m_tready is low,
//   loads and clears are still taken, and a further evaluation holds in its
//   handoff state until the register frees.
//   Reset empties the table (fill count zero, no clearing pass) and sets
//   scale_factor to 1.0. scale_factor sits on the APB port at address 0.
// ----------------------------------------------------------------------------
module matched_point_difference_vector (
	input  logic         clk,
	input  logic         arst_n,
	// request stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// point_number[26:0], row[58:27], col[90:59], var_row[121:91],
	// var_col[152:122], cov_rc[184:153], zero pad
	input  logic [191:0] s_tdata,
	// mode[1:0]
	input  logic [1:0]   s_tuser,
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// start_number[29:0], end_number[59:30], start_row[91:60],
	// start_col[123:92], start_var_row[154:124], start_var_col[185:155],
	// start_cov[217:186], end_row[249:218], end_col[281:250],
	// end_var_row[312:282], end_var_col[343:313], end_cov[375:344]
	output logic [375:0] m_tdata,
	// configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	mpdv_pkg::entry_t   in_pt, tbl_data;
	mpdv_pkg::cmd_t     cmd;
	mpdv_pkg::status_t  status;
	mpdv_pkg::tbl_cmd_t tbl_cmd;
	logic [31:0]        scale_q;

	// request fields
	assign in_pt.num     = s_tdata[26:0];
	assign in_pt.row     = s_tdata[58:27];
	assign in_pt.col     = s_tdata[90:59];
	assign in_pt.var_row = s_tdata[121:91];
	assign in_pt.var_col = s_tdata[152:122];
	assign in_pt.cov     = s_tdata[184:153];

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == mpdv_pkg::REG_SCALE) ? scale_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= mpdv_pkg::SCALE_RESET;
		end else if (psel && penable && pwrite && pready
		             && (paddr[2] == mpdv_pkg::REG_SCALE)) begin
			scale_q <= pwdata;
		end
	end

	mpdv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.mode     (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd),
		.tbl_cmd  (tbl_cmd)
	);

	mpdv_table u_table (
		.clk     (clk),
		.cmd     (tbl_cmd),
		.wr_data (in_pt),
		.rd_data (tbl_data)
	);

	mpdv_datapath u_datapath (
		.clk           (clk),
		.cmd           (cmd),
		.scale         (scale_q),
		.in_pt         (in_pt),
		.tbl_data      (tbl_data),
		.status        (status),
		.start_number  (m_tdata[29:0]),
		.end_number    (m_tdata[59:30]),
		.start_row     (m_tdata[91:60]),
		.start_col     (m_tdata[123:92]),
		.start_var_row (m_tdata[154:124]),
		.start_var_col (m_tdata[185:155]),
		.start_cov     (m_tdata[217:186]),
		.end_row       (m_tdata[249:218]),
		.end_col       (m_tdata[281:250]),
		.end_var_row   (m_tdata[312:282]),
		.end_var_col   (m_tdata[343:313]),
		.end_cov       (m_tdata[375:344])
	);

endmodule

@@ sv/mpdv_table.sv @@
// ----------------------------------------------------------------------------
// mpdv_table
// Measured point store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mpdv_table (
	input  logic               clk,
	input  mpdv_pkg::tbl_cmd_t cmd,
	input  mpdv_pkg::entry_t   wr_data,
	output mpdv_pkg::entry_t   rd_data
);

	mpdv_pkg::entry_t mem_q [mpdv_pkg::TABLE_DEPTH];
	mpdv_pkg::entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[cmd.wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[cmd.rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/mpdv_datapath.sv @@
// ----------------------------------------------------------------------------
// mpdv_datapath
// Reference capture, key compare and the shared 32x32 multiply-accumulate
// unit that builds the difference vector over the micro-program.
// ----------------------------------------------------------------------------
module mpdv_datapath (
	input  logic              clk,
	input  mpdv_pkg::cmd_t    cmd,
	input  logic [31:0]       scale,
	input  mpdv_pkg::entry_t  in_pt,
	input  mpdv_pkg::entry_t  tbl_data,
	output mpdv_pkg::status_t status,
	output logic [29:0]       start_number,
	output logic [29:0]       end_number,
	output logic [31:0]       start_row,
	output logic [31:0]       start_col,
	output logic [30:0]       start_var_row,
	output logic [30:0]       start_var_col,
	output logic [31:0]       start_cov,
	output logic [31:0]       end_row,
	output logic [31:0]       end_col,
	output logic [30:0]       end_var_row,
	output logic [30:0]       end_var_col,
	output logic [31:0]       end_cov
);

	localparam int AW = mpdv_pkg::ACC_W;
	localparam logic signed [AW-1:0] S32_MAX = {{(AW-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [AW-1:0] S32_MIN = {{(AW-31){1'b1}}, 31'b0};

	mpdv_pkg::entry_t ref_q;
	mpdv_pkg::entry_t meas_q;
	mpdv_pkg::uop_t   uop;

	logic [31:0] mag_s_q, mag_oms_q, mag_dr_q, mag_dc_q, mag_mcv_q, mag_cv_q;
	logic        neg_s_q, neg_oms_q, neg_dr_q, neg_dc_q, neg_mcv_q, neg_cv_q;
	logic [62:0] s2_q, om2_q;
	logic [63:0] prod_q;
	logic        sign_q, sh_q;
	logic signed [AW-1:0] acc_q;
	logic [31:0] res_row_q, res_col_q, res_cov_q;
	logic [30:0] res_vr_q, res_vc_q;

	logic [31:0] a_op, b_op;
	logic        a_neg, b_neg;
	logic signed [33:0] oms_w, dr_w, dc_w;
	logic [95:0] term_w;
	logic [AW-1:0] term_ext;
	logic [29:0] n10_w;

	// absolute value on a 34-bit signed value
	function automatic logic [33:0] mag34(input logic signed [33:0] x);
		return x[33] ? 34'(-x) : 34'(x);
	endfunction

	// signed 32-bit saturation of an already shifted value
	function automatic logic [31:0] sat_s32(input logic signed [AW-1:0] m);
		logic [31:0] r;
		r = m[31:0];
		if (m > S32_MAX) begin
			r = 32'h7fff_ffff;
		end else if (m < S32_MIN) begin
			r = 32'h8000_0000;
		end
		return r;
	endfunction

	// unsigned 31-bit saturation
	function automatic logic [30:0] sat_u31(input logic signed [AW-1:0] m);
		return (m > S32_MAX) ? 31'h7fff_ffff : m[30:0];
	endfunction

	assign uop = mpdv_pkg::uop_at(cmd.step);

	// key compare against the registered table read
	assign status.match = (tbl_data.num == ref_q.num);

	// reference and matched entry capture
	always_ff @(posedge clk) begin
		if (cmd.load_ref) begin
			ref_q <= in_pt;
		end
		if (cmd.capture_hit) begin
			meas_q <= tbl_data;
		end
	end

	// operand differences
	assign oms_w = 34'sd65536 - 34'(signed'(scale));
	assign dr_w  = 34'(signed'(meas_q.row)) - 34'(signed'(ref_q.row));
	assign dc_w  = 34'(signed'(meas_q.col)) - 34'(signed'(ref_q.col));

	// multiplier operand selection
	always_comb begin
		unique case (uop.a_sel)
			mpdv_pkg::A_S:     a_op = mag_s_q;
			mpdv_pkg::A_OMS:   a_op = mag_oms_q;
			mpdv_pkg::A_DR:    a_op = mag_dr_q;
			mpdv_pkg::A_DC:    a_op = mag_dc_q;
			mpdv_pkg::A_S2LO:  a_op = s2_q[31:0];
			mpdv_pkg::A_S2HI:  a_op = {1'b0, s2_q[62:32]};
			mpdv_pkg::A_OM2LO: a_op = om2_q[31:0];
			mpdv_pkg::A_OM2HI: a_op = {1'b0, om2_q[62:32]};
			default:           a_op = '0;
		endcase
		unique case (uop.a_sel)
			mpdv_pkg::A_S:   a_neg = neg_s_q;
			mpdv_pkg::A_OMS: a_neg = neg_oms_q;
			mpdv_pkg::A_DR:  a_neg = neg_dr_q;
			mpdv_pkg::A_DC:  a_neg = neg_dc_q;
			default:         a_neg = 1'b0;
		endcase
		unique case (uop.b_sel)
			mpdv_pkg::B_S:   b_op = mag_s_q;
			mpdv_pkg::B_OMS: b_op = mag_oms_q;
			mpdv_pkg::B_MVR: b_op = {1'b0, meas_q.var_row};
			mpdv_pkg::B_VR:  b_op = {1'b0, ref_q.var_row};
			mpdv_pkg::B_MVC: b_op = {1'b0, meas_q.var_col};
			mpdv_pkg::B_VC:  b_op = {1'b0, ref_q.var_col};
			mpdv_pkg::B_MCV: b_op = mag_mcv_q;
			mpdv_pkg::B_CV:  b_op = mag_cv_q;
			default:         b_op = '0;
		endcase
		unique case (uop.b_sel)
			mpdv_pkg::B_S:   b_neg = neg_s_q;
			mpdv_pkg::B_OMS: b_neg = neg_oms_q;
			mpdv_pkg::B_MCV: b_neg = neg_mcv_q;
			mpdv_pkg::B_CV:  b_neg = neg_cv_q;
			default:         b_neg = 1'b0;
		endcase
	end

	// shifted product for accumulation
	assign term_w   = sh_q ? {prod_q, 32'b0} : {32'b0, prod_q};
	assign term_ext = {{(AW-96){1'b0}}, term_w};

	// multiply phase
	always_ff @(posedge clk) begin
		if (!cmd.phase) begin
			prod_q <= a_op * b_op;
			sign_q <= a_neg ^ b_neg;
			sh_q   <= uop.sh32;
		end
	end

	// accumulate / writeback phase
	always_ff @(posedge clk) begin
		if (cmd.phase) begin
			unique case (uop.kind)
				mpdv_pkg::K_MAG: begin
					mag_s_q   <= 32'(mag34(34'(signed'(scale))));
					neg_s_q   <= scale[31];
					mag_oms_q <= 32'(mag34(oms_w));
					neg_oms_q <= oms_w[33];
					mag_dr_q  <= 32'(mag34(dr_w));
					neg_dr_q  <= dr_w[33];
					mag_dc_q  <= 32'(mag34(dc_w));
					neg_dc_q  <= dc_w[33];
					mag_mcv_q <= 32'(mag34(34'(signed'(meas_q.cov))));
					neg_mcv_q <= meas_q.cov[31];
					mag_cv_q  <= 32'(mag34(34'(signed'(ref_q.cov))));
					neg_cv_q  <= ref_q.cov[31];
				end
				mpdv_pkg::K_S2:  s2_q  <= prod_q[62:0];
				mpdv_pkg::K_OM2: om2_q <= prod_q[62:0];
				mpdv_pkg::K_INIT_ROW:
					acc_q <= {{(AW-48){ref_q.row[31]}}, ref_q.row, 16'd0};
				mpdv_pkg::K_INIT_COL:
					acc_q <= {{(AW-48){ref_q.col[31]}}, ref_q.col, 16'd0};
				mpdv_pkg::K_MAC:
					acc_q <= sign_q ? acc_q - signed'(term_ext) : acc_q + signed'(term_ext);
				mpdv_pkg::K_FIN_ROW: begin
					res_row_q <= sat_s32(acc_q >>> 16);
					acc_q     <= '0;
				end
				mpdv_pkg::K_FIN_COL: begin
					res_col_q <= sat_s32(acc_q >>> 16);
					acc_q     <= '0;
				end
				mpdv_pkg::K_FIN_VR: begin
					res_vr_q <= sat_u31(acc_q >>> 32);
					acc_q    <= '0;
				end
				mpdv_pkg::K_FIN_VC: begin
					res_vc_q <= sat_u31(acc_q >>> 32);
					acc_q    <= '0;
				end
				mpdv_pkg::K_FIN_COV: begin
					res_cov_q <= sat_s32(acc_q >>> 32);
					acc_q     <= '0;
				end
				default: ;
			endcase
		end
	end

	// point number times ten, wrapped to 30 bits
	assign n10_w = 30'({ref_q.num, 3'b0}) + 30'({ref_q.num, 1'b0});

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			start_number  <= n10_w;
			end_number    <= n10_w + 30'd1;
			start_row     <= ref_q.row;
			start_col     <= ref_q.col;
			start_var_row <= ref_q.var_row;
			start_var_col <= ref_q.var_col;
			start_cov     <= ref_q.cov;
			end_row       <= res_row_q;
			end_col       <= res_col_q;
			end_var_row   <= res_vr_q;
			end_var_col   <= res_vc_q;
			end_cov       <= res_cov_q;
		end
	end

endmodule

@@ sv/mpdv_ctrl.sv @@
// ----------------------------------------------------------------------------
// mpdv_ctrl
// Controller: request decode, fill count, table search and micro-program
// sequencing, result handoff.
// ----------------------------------------------------------------------------
module mpdv_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [1:0]         mode,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  mpdv_pkg::status_t  status,
	output mpdv_pkg::cmd_t     cmd,
	output mpdv_pkg::tbl_cmd_t tbl_cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_MATH   = 2'd2;
	localparam logic [1:0] ST_POST   = 2'd3;
	localparam logic [mpdv_pkg::CNT_W-1:0] DEPTH = mpdv_pkg::CNT_W'(mpdv_pkg::TABLE_DEPTH);
	localparam logic [mpdv_pkg::STEP_W-1:0] LAST_STEP =
		mpdv_pkg::STEP_W'(mpdv_pkg::NSTEPS - 1);

	logic [1:0]                    state_q;
	logic [mpdv_pkg::CNT_W-1:0]    count_q, idx_q;
	logic                          pend_q;
	logic [mpdv_pkg::STEP_W-1:0]   step_q;
	logic                          phase_q;
	logic                          out_valid_q;
	logic                          s_acc, hit, out_load;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign hit      = (state_q == ST_SEARCH) && pend_q && status.match;
	assign out_load = (state_q == ST_POST) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;

	// command outputs
	assign cmd.load_ref    = s_acc && (mode == mpdv_pkg::MODE_EVAL);
	assign cmd.capture_hit = hit;
	assign cmd.step        = step_q;
	assign cmd.phase       = phase_q;
	assign cmd.out_load    = out_load;

	assign tbl_cmd.wr_en   = s_acc && (mode == mpdv_pkg::MODE_LOAD) && (count_q < DEPTH);
	assign tbl_cmd.wr_addr = count_q[mpdv_pkg::ADDR_W-1:0];
	assign tbl_cmd.rd_addr = idx_q[mpdv_pkg::ADDR_W-1:0];

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			pend_q  <= 1'b0;
			step_q  <= '0;
			phase_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						unique case (mode)
							mpdv_pkg::MODE_LOAD: begin
								if (count_q < DEPTH) begin
									count_q <= count_q + 1'b1;
								end
							end
							mpdv_pkg::MODE_EVAL: begin
								idx_q   <= '0;
								pend_q  <= 1'b0;
								state_q <= ST_SEARCH;
							end
							mpdv_pkg::MODE_CLEAR: count_q <= '0;
							default: ;
						endcase
					end
				end
				// one read issued per cycle, compare in the cycle after it
				ST_SEARCH: begin
					if (hit) begin
						pend_q  <= 1'b0;
						step_q  <= '0;
						phase_q <= 1'b0;
						state_q <= ST_MATH;
					end else if (idx_q < count_q) begin
						idx_q  <= idx_q + 1'b1;
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				// each micro-op has a multiply phase, then an accumulate phase
				ST_MATH: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						if (step_q == LAST_STEP) begin
							state_q <= ST_POST;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				ST_POST: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH) else $error("fill count beyond table depth");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || m_tready)) else $error("pending result overwritten");
	a_hit_to_math: assert property (@(posedge clk) disable iff (!arst_n)
		hit |=> (state_q == ST_MATH) && (step_q == '0)) else $error("hit did not start math");
	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (idx_q <= count_q)) else $error("search past fill count");

endmodule

@@ dv/matched_point_difference_vector_tb.sv @@
// ----------------------------------------------------------------------------
// matched_point_difference_vector_tb
// Loads measured points, evaluates reference points against them and checks
// every difference vector field by field against a predictor of the table
// and the Q16.16 arithmetic, over several scale factors and random idling.
// ----------------------------------------------------------------------------
module matched_point_difference_vector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 320;
	localparam int HOLD_CYCLES    = 400;
	// mode code with no function
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// result fields, highest bits first so the struct maps onto m_tdata
	typedef struct packed {
		logic [31:0] end_cov;
		logic [30:0] end_var_col;
		logic [30:0] end_var_row;
		logic [31:0] end_col;
		logic [31:0] end_row;
		logic [31:0] start_cov;
		logic [30:0] start_var_col;
		logic [30:0] start_var_row;
		logic [31:0] start_col;
		logic [31:0] start_row;
		logic [29:0] end_number;
		logic [29:0] start_number;
	} vector_t;

	// saturate a wide signed value to 32 bits
	function automatic logic [31:0] sat_s32(input logic signed [127:0] v);
		if (v > 128'sh7FFF_FFFF) return 32'h7FFF_FFFF;
		if (v < -128'sh8000_0000) return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic logic [30:0] sat_u31(input logic signed [127:0] v);
		if (v > 128'sh7FFF_FFFF) return 31'h7FFF_FFFF;
		return v[30:0];
	endfunction

	class vector_scoreboard;
		mpdv_pkg::entry_t points[mpdv_pkg::TABLE_DEPTH];
		int               fill;
		logic [31:0]      scale;
		vector_t          pending_vectors[$];
		int               errors;

		function new();
			fill = 0;
			scale = mpdv_pkg::SCALE_RESET;
			errors = 0;
		endfunction

		// table update and vector prediction for one accepted request
		function void note_request(input logic [1:0] mode, input mpdv_pkg::entry_t p);
			int hit;
			vector_t v;
			logic signed [127:0] s, oms, s2, om2, acc;
			longint unsigned n10;
			hit = -1;
			if (mode == mpdv_pkg::MODE_CLEAR) begin
				fill = 0;
			end else if (mode == mpdv_pkg::MODE_LOAD) begin
				if (fill < mpdv_pkg::TABLE_DEPTH) begin
					points[fill] = p;
					fill++;
				end
			end else if (mode == mpdv_pkg::MODE_EVAL) begin
				for (int i = 0; i < fill; i++) begin
					if (points[i].num == p.num) begin
						hit = i;
						break;
					end
				end
				if (hit >= 0) begin
					s = $signed(scale);
					oms = 128'sd65536 - s;
					s2 = (s < 0) ? -s : s;
					s2 = s2 * s2;
					om2 = (oms < 0) ? -oms : oms;
					om2 = om2 * om2;
					n10 = longint'(p.num) * 10;
					v.start_number = n10[29:0];
					n10 = n10 + 1;
					v.end_number = n10[29:0];
					v.start_row = p.row;
					v.start_col = p.col;
					v.start_var_row = p.var_row;
					v.start_var_col = p.var_col;
					v.start_cov = p.cov;
					acc = ($signed({{96{p.row[31]}}, p.row}) <<< 16)
						+ ($signed({{96{points[hit].row[31]}}, points[hit].row})
						- $signed({{96{p.row[31]}}, p.row})) * s;
					v.end_row = sat_s32(acc >>> 16);
					acc = ($signed({{96{p.col[31]}}, p.col}) <<< 16)
						+ ($signed({{96{points[hit].col[31]}}, points[hit].col})
						- $signed({{96{p.col[31]}}, p.col})) * s;
					v.end_col = sat_s32(acc >>> 16);
					acc = s2 * $signed({97'b0, points[hit].var_row})
						+ om2 * $signed({97'b0, p.var_row});
					v.end_var_row = sat_u31(acc >>> 32);
					acc = s2 * $signed({97'b0, points[hit].var_col})
						+ om2 * $signed({97'b0, p.var_col});
					v.end_var_col = sat_u31(acc >>> 32);
					acc = s2 * $signed({{96{points[hit].cov[31]}}, points[hit].cov})
						+ om2 * $signed({{96{p.cov[31]}}, p.cov});
					v.end_cov = sat_s32(acc >>> 32);
					pending_vectors.push_back(v);
				end
			end
		endfunction

		function void report(input string what, input logic [31:0] e, input logic [31:0] a);
			errors++;
			if (errors <= 10)
				$display("mismatch %s: expected %h actual %h", what, e, a);
		endfunction

		function void field(input string what, input logic [31:0] e, input logic [31:0] a);
			if (e !== a) report(what, e, a);
		endfunction

		// compare one accepted vector with the oldest prediction
		function void check_vector(input vector_t a);
			vector_t e;
			if (pending_vectors.size() == 0) begin
				report("unexpected vector start_number", 32'hx, 32'(a.start_number));
				return;
			end
			e = pending_vectors.pop_front();
			field("start_number", 32'(e.start_number), 32'(a.start_number));
			field("end_number", 32'(e.end_number), 32'(a.end_number));
			field("start_row", e.start_row, a.start_row);
			field("start_col", e.start_col, a.start_col);
			field("start_var_row", 32'(e.start_var_row), 32'(a.start_var_row));
			field("start_var_col", 32'(e.start_var_col), 32'(a.start_var_col));
			field("start_cov", e.start_cov, a.start_cov);
			field("end_row", e.end_row, a.end_row);
			field("end_col", e.end_col, a.end_col);
			field("end_var_row", 32'(e.end_var_row), 32'(a.end_var_row));
			field("end_var_col", 32'(e.end_var_col), 32'(a.end_var_col));
			field("end_cov", e.end_cov, a.end_cov);
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [191:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [375:0] m_tdata;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	vector_scoreboard sb;
	bit calm;
	bit hold_req;
	int sent;
	int quiet_cycles;
	logic [26:0] pool[8];

	matched_point_difference_vector u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// send one request and wait for its acceptance
	task automatic send_request(input logic [1:0] mode, input mpdv_pkg::entry_t p);
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {8'b0, p.cov, p.var_col, p.var_row, p.col, p.row, p.num};
		do @(posedge clk); while (!s_tready);
		sb.note_request(mode, p);
		sent++;
		if (!calm && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending_vectors.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// apb write of the scale factor, block idle
	task automatic write_scale(input logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'(mpdv_pkg::REG_SCALE) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.scale = value;
		quiet_cycles = 0;
	endtask

	function automatic logic [31:0] pick_s32();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [30:0] pick_u31();
		case ($urandom_range(5))
			0: return 31'h0;
			1: return 31'h7FFF_FFFF;
			default: return 31'($urandom());
		endcase
	endfunction

	function automatic mpdv_pkg::entry_t make_point(input logic [26:0] num);
		mpdv_pkg::entry_t p;
		p.num = num;
		p.row = pick_s32();
		p.col = pick_s32();
		p.var_row = pick_u31();
		p.var_col = pick_u31();
		p.cov = pick_s32();
		return p;
	endfunction

	// result sink with random stalls and one long hold-off
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			sb.check_vector(vector_t'(m_tdata));
		end
	end

	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			m_tready <= calm || ($urandom_range(99) >= 11);
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("matched_point_difference_vector verification failed");
			$finish;
		end
	end

	initial begin
		logic [31:0] scales[9];
		int phase;
		int loads;
		scales = '{32'h0001_0000, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000,
			32'h0002_0000, 32'h0000_8000, 32'h0, 32'h0};
		sb = new();
		calm = 1'b0;
		hold_req = 1'b0;
		sent = 0;
		quiet_cycles = 0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= mpdv_pkg::MODE_LOAD;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, duplicates, wrap of numbers, no match, unused mode
		send_request(mpdv_pkg::MODE_LOAD, '{27'd0, 32'h7FFF_FFFF, 32'h8000_0000,
			31'h7FFF_FFFF, 31'h0, 32'h7FFF_FFFF});
		send_request(mpdv_pkg::MODE_LOAD, '{27'h7FF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			31'h0, 31'h7FFF_FFFF, 32'h8000_0000});
		send_request(mpdv_pkg::MODE_LOAD, make_point(27'd0));
		send_request(mpdv_pkg::MODE_LOAD, make_point(27'd100000000));
		send_request(mpdv_pkg::MODE_EVAL, '{27'd0, 32'h8000_0000, 32'h7FFF_FFFF, 31'h0,
			31'h7FFF_FFFF, 32'h8000_0000});
		send_request(mpdv_pkg::MODE_EVAL, '{27'h7FF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			31'h7FFF_FFFF, 31'h0, 32'h7FFF_FFFF});
		send_request(mpdv_pkg::MODE_EVAL, make_point(27'd100000000));
		send_request(mpdv_pkg::MODE_EVAL, make_point(27'd5));
		send_request(MODE_UNUSED, make_point(27'd5));
		send_request(mpdv_pkg::MODE_EVAL, make_point(27'd0));
		send_request(mpdv_pkg::MODE_CLEAR, make_point(27'd0));
		send_request(mpdv_pkg::MODE_EVAL, make_point(27'd0));
		send_request(mpdv_pkg::MODE_LOAD, make_point(27'd7));
		send_request(mpdv_pkg::MODE_EVAL, make_point(27'd7));
		wait_drained();

		// random phases, one scale factor each
		phase = 0;
		while (sent < 2000) begin
			write_scale(phase < 7 ? scales[phase] :
				($urandom_range(1) ? $urandom() : $urandom_range(32'h0004_0000)));
			calm = (phase == 2);
			for (int i = 0; i < 8; i++)
				pool[i] = $urandom_range(3) == 0 ? 27'($urandom()) : 27'($urandom_range(20));
			send_request(mpdv_pkg::MODE_CLEAR, make_point(pool[0]));
			loads = (phase % 4 == 3) ? $urandom_range(256, 270) : $urandom_range(1, 40);
			for (int i = 0; i < loads; i++)
				send_request(mpdv_pkg::MODE_LOAD, make_point(pool[$urandom_range(7)]));
			if (phase == 1) hold_req = 1'b1;
			for (int i = 0; i < 60; i++) begin
				case ($urandom_range(19))
					0: send_request(mpdv_pkg::MODE_LOAD, make_point(pool[$urandom_range(7)]));
					1: send_request(MODE_UNUSED, make_point(27'($urandom())));
					2: send_request(mpdv_pkg::MODE_EVAL, make_point(27'($urandom())));
					default: send_request(mpdv_pkg::MODE_EVAL,
						make_point(pool[$urandom_range(7)]));
				endcase
			end
			wait_drained();
			phase++;
		end
		calm = 1'b0;

		if (sb.pending_vectors.size() != 0)
			sb.errors++;
		if (sb.errors == 0)
			$display("matched_point_difference_vector verification clean");
		else
			$display("matched_point_difference_vector verification failed");
		$finish;
	end

endmodule

@@ files.f @@
sv/mpdv_pkg.sv
sv/mpdv_table.sv
sv/mpdv_datapath.sv
sv/mpdv_ctrl.sv
sv/matched_point_difference_vector.sv
dv/matched_point_difference_vector_tb.sv
